>>> src/timed_semaphore_wait_queue_assert.svh
// assertion macros shared by the wait queue modules
// depends on nothing; each user supplies clock and reset signals by these names
`ifndef TIMED_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH
`define TIMED_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH

// same-cycle implication
`define TSWQ_ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSWQ_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> src/tswq_pkg.sv
// types and constants of the timed semaphore wait queue
// depends on nothing
`timescale 1ns / 1ps

package tswq_pkg;

   localparam int QUEUE_DEPTH = 16;

   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_SIGNAL  = 2'd1;
   localparam logic [1:0] FUNC_TICK    = 2'd2;
   localparam logic [1:0] FUNC_REMOVE  = 2'd3;

   typedef struct packed {
      logic [15:0] thread;
      logic [15:0] remaining;
      logic        forever_flag;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CNT_RD,
      S_CNT_CHK,
      S_WALK_RD,
      S_WALK_CHK,
      S_EMIT_REL,
      S_EMIT_FIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic cnt_step;
      logic walk_init;
      logic keep;
      logic take;
      logic emit_rel;
      logic emit_fin;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] func;
      logic       cnt_zero;
      logic       hit;
      logic       out_free;
   } status_type;

endpackage

>>> src/tswq_if.sv
// request and response channel interfaces of the wait queue
// depends on nothing
`timescale 1ns / 1ps

interface tswq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] thread_id;
   logic [15:0] wait_ticks;
   logic        wait_forever;
   logic [4:0]  release_count;

   modport source (output valid, func, thread_id, wait_ticks, wait_forever, release_count,
                   input ready);
   modport sink (input valid, func, thread_id, wait_ticks, wait_forever, release_count,
                 output ready);
endinterface

interface tswq_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] woken_id;
   logic        woken;
   logic        by_signal;
   logic [4:0]  credit_add;
   logic [4:0]  released_total;
   logic        queue_full;
   logic [4:0]  waiting_count;
   logic        last_result;

   modport source (output valid, woken_id, woken, by_signal, credit_add, released_total,
                   queue_full, waiting_count, last_result, input ready);
   modport sink (input valid, woken_id, woken, by_signal, credit_add, released_total,
                 queue_full, waiting_count, last_result, output ready);
endinterface

>>> src/tswq_datapath.sv
// wait queue datapath: circular entry memory, walk pointers, output register
// depends on tswq_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "timed_semaphore_wait_queue_assert.svh"

module tswq_datapath #(
   parameter int DEPTH = tswq_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tswq_pkg::cmd_type     cmd,
   output tswq_pkg::status_type  status,
   input  logic [1:0]            req_func,
   input  logic [15:0]           req_thread_id,
   input  logic [15:0]           req_wait_ticks,
   input  logic                  req_wait_forever,
   input  logic [4:0]            req_release_count,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [15:0]           rsp_woken_id,
   output logic                  rsp_woken,
   output logic                  rsp_by_signal,
   output logic [4:0]            rsp_credit_add,
   output logic [4:0]            rsp_released_total,
   output logic                  rsp_queue_full,
   output logic [4:0]            rsp_waiting_count,
   output logic                  rsp_last_result
);

   localparam int OW = $clog2(DEPTH + 1);
   localparam int PW = $clog2(DEPTH);
   localparam int MW = (OW > 5) ? OW : 5;

   tswq_pkg::entry_type mem [DEPTH];
   tswq_pkg::entry_type rdata_ff;
   tswq_pkg::entry_type wdata;
   logic                mem_we;
   logic [PW-1:0]       mem_waddr;

   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [PW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [OW-1:0] occ_ff, occ_in, fin_ff, fin_in, cnt_ff, cnt_in;
   logic [OW-1:0] relc_ff, relc_in, sig_cnt;
   logic [1:0]    func_ff, func_in;
   logic [15:0]   tid_ff, tid_in, rel_id_ff, rel_id_in;
   logic [4:0]    n_ff, n_in, total_ff, total_in;
   logic          found_ff, found_in, full_ff, full_in;
   logic          hit, out_free;

   logic          valid_ff, valid_in;
   logic [15:0]   o_id_ff, o_id_in;
   logic          o_woken_ff, o_woken_in, o_sig_ff, o_sig_in;
   logic [4:0]    o_credit_ff, o_credit_in, o_total_ff, o_total_in, o_wait_ff, o_wait_in;
   logic          o_full_ff, o_full_in, o_last_ff, o_last_in;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // release decision on the entry just read
   always_comb begin
      case (func_ff)
         tswq_pkg::FUNC_SIGNAL: hit = 1'b1;
         tswq_pkg::FUNC_TICK:   hit = !rdata_ff.forever_flag && (rdata_ff.remaining == 16'd1);
         tswq_pkg::FUNC_REMOVE: hit = !found_ff && (rdata_ff.thread == tid_ff);
         default:               hit = 1'b0;
      endcase
   end

   assign out_free = !valid_ff || rsp_ready;
   assign sig_cnt  = (MW'(req_release_count) < MW'(occ_ff)) ? OW'(req_release_count) : occ_ff;

   always_comb begin
      status.func     = func_ff;
      status.cnt_zero = (cnt_ff == '0);
      status.hit      = hit;
      status.out_free = out_free;
   end

   // entry write port: enqueue at the tail or compaction during a walk
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = tail_ff;
      wdata     = rdata_ff;
      if (cmd.keep) begin
         mem_we    = 1'b1;
         mem_waddr = wr_ff;
         if (!rdata_ff.forever_flag && func_ff == tswq_pkg::FUNC_TICK)
            wdata.remaining = rdata_ff.remaining - 16'd1;
      end else if (cmd.start && req_func == tswq_pkg::FUNC_ENQUEUE &&
                   occ_ff != OW'(DEPTH)) begin
         mem_we                  = 1'b1;
         wdata.thread            = req_thread_id;
         wdata.remaining         = req_wait_ticks;
         wdata.forever_flag      = req_wait_forever;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= wdata;
      rdata_ff <= mem[rd_ff];
   end

   // next values of pointers, counters and the output register
   always_comb begin
      head_in = head_ff;  tail_in = tail_ff;  rd_in = rd_ff;  wr_in = wr_ff;
      occ_in = occ_ff;    fin_in = fin_ff;    cnt_in = cnt_ff; relc_in = relc_ff;
      func_in = func_ff;  tid_in = tid_ff;    n_in = n_ff;     total_in = total_ff;
      found_in = found_ff; full_in = full_ff; rel_id_in = rel_id_ff;
      valid_in = rsp_ready ? 1'b0 : valid_ff;
      o_id_in = o_id_ff;  o_woken_in = o_woken_ff; o_sig_in = o_sig_ff;
      o_credit_in = o_credit_ff; o_total_in = o_total_ff; o_wait_in = o_wait_ff;
      o_full_in = o_full_ff; o_last_in = o_last_ff;

      if (cmd.start) begin
         func_in = req_func;  tid_in = req_thread_id;  n_in = req_release_count;
         rd_in = head_ff;     wr_in = head_ff;         found_in = 1'b0;
         total_in = '0;       relc_in = '0;            full_in = 1'b0;
         case (req_func)
            tswq_pkg::FUNC_ENQUEUE: begin
               cnt_in = '0;
               if (occ_ff == OW'(DEPTH)) begin
                  full_in = 1'b1;
                  fin_in  = occ_ff;
               end else begin
                  tail_in = ptr_inc(tail_ff);
                  occ_in  = occ_ff + 1'b1;
                  fin_in  = occ_ff + 1'b1;
               end
            end
            tswq_pkg::FUNC_SIGNAL: begin
               cnt_in = sig_cnt;
               fin_in = occ_ff - sig_cnt;
            end
            default: begin
               cnt_in = occ_ff;
               fin_in = occ_ff;
            end
         endcase
      end
      if (cmd.cnt_step) begin
         if (hit) relc_in = relc_ff + 1'b1;
         rd_in  = ptr_inc(rd_ff);
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.walk_init) begin
         rd_in  = head_ff;
         cnt_in = occ_ff;
         fin_in = occ_ff - relc_ff;
      end
      if (cmd.keep) begin
         wr_in  = ptr_inc(wr_ff);
         rd_in  = ptr_inc(rd_ff);
         cnt_in = cnt_ff - 1'b1;
      end
      if (cmd.take) begin
         rel_id_in = rdata_ff.thread;
         rd_in     = ptr_inc(rd_ff);
         cnt_in    = cnt_ff - 1'b1;
         found_in  = 1'b1;
         total_in  = total_ff + 5'd1;
         if (func_ff == tswq_pkg::FUNC_REMOVE) fin_in = occ_ff - 1'b1;
      end
      if (cmd.emit_rel) begin
         valid_in = 1'b1;  o_id_in = rel_id_ff;  o_woken_in = 1'b1;
         o_sig_in = (func_ff == tswq_pkg::FUNC_SIGNAL);
         o_credit_in = (func_ff == tswq_pkg::FUNC_TICK) ? 5'd1 : 5'd0;
         o_total_in = '0;  o_full_in = 1'b0;  o_wait_in = 5'(fin_ff);  o_last_in = 1'b0;
      end
      if (cmd.emit_fin) begin
         valid_in = 1'b1;  o_id_in = '0;  o_woken_in = 1'b0;  o_sig_in = 1'b0;
         o_credit_in = (func_ff == tswq_pkg::FUNC_SIGNAL) ? n_ff : 5'd0;
         o_total_in  = (func_ff == tswq_pkg::FUNC_SIGNAL) ? total_ff : 5'd0;
         o_full_in = full_ff;  o_wait_in = 5'(fin_ff);  o_last_in = 1'b1;
         occ_in = fin_ff;
         if (func_ff == tswq_pkg::FUNC_SIGNAL) head_in = rd_ff;
         else if (func_ff != tswq_pkg::FUNC_ENQUEUE) tail_in = wr_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;  tail_ff <= '0;  occ_ff <= '0;  valid_ff <= 1'b0;
         found_ff <= 1'b0;  func_ff <= tswq_pkg::FUNC_ENQUEUE;
      end else begin
         head_ff <= head_in;  tail_ff <= tail_in;  occ_ff <= occ_in;  valid_ff <= valid_in;
         found_ff <= found_in;  func_ff <= func_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ff <= rd_in;  wr_ff <= wr_in;  fin_ff <= fin_in;  cnt_ff <= cnt_in;
      relc_ff <= relc_in;  tid_ff <= tid_in;  n_ff <= n_in;  total_ff <= total_in;
      full_ff <= full_in;  rel_id_ff <= rel_id_in;
      o_id_ff <= o_id_in;  o_woken_ff <= o_woken_in;  o_sig_ff <= o_sig_in;
      o_credit_ff <= o_credit_in;  o_total_ff <= o_total_in;  o_wait_ff <= o_wait_in;
      o_full_ff <= o_full_in;  o_last_ff <= o_last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_woken_id       = o_id_ff;
   assign rsp_woken          = o_woken_ff;
   assign rsp_by_signal      = o_sig_ff;
   assign rsp_credit_add     = o_credit_ff;
   assign rsp_released_total = o_total_ff;
   assign rsp_queue_full     = o_full_ff;
   assign rsp_waiting_count  = o_wait_ff;
   assign rsp_last_result    = o_last_ff;

   `TSWQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_ff <= OW'(DEPTH), "occupancy above depth")
   `TSWQ_ASSERT_NOW(a_emit_free, cmd.emit_rel || cmd.emit_fin, out_free, "result overwritten")
   `TSWQ_ASSERT_NOW(a_keep_take, cmd.keep || cmd.take, !(cmd.keep && cmd.take) && !status.cnt_zero, "walk step past the end")
   `TSWQ_ASSERT_NEXT(a_emit_valid, cmd.emit_rel || cmd.emit_fin, valid_ff, "emitted result not held")

endmodule

>>> src/tswq_controller.sv
// wait queue controller: sequences count pass, walk and result emission
// depends on tswq_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "timed_semaphore_wait_queue_assert.svh"

module tswq_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_func,
   output logic                 req_ready,
   input  tswq_pkg::status_type status,
   output tswq_pkg::cmd_type    cmd
);

   tswq_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tswq_pkg::S_IDLE:
            if (req_valid) begin
               case (req_func)
                  tswq_pkg::FUNC_ENQUEUE: state_in = tswq_pkg::S_EMIT_FIN;
                  tswq_pkg::FUNC_TICK:    state_in = tswq_pkg::S_CNT_RD;
                  default:                state_in = tswq_pkg::S_WALK_RD;
               endcase
            end
         tswq_pkg::S_CNT_RD:
            state_in = status.cnt_zero ? tswq_pkg::S_WALK_RD : tswq_pkg::S_CNT_CHK;
         tswq_pkg::S_CNT_CHK:  state_in = tswq_pkg::S_CNT_RD;
         tswq_pkg::S_WALK_RD:
            state_in = status.cnt_zero ? tswq_pkg::S_EMIT_FIN : tswq_pkg::S_WALK_CHK;
         tswq_pkg::S_WALK_CHK:
            state_in = status.hit ? tswq_pkg::S_EMIT_REL : tswq_pkg::S_WALK_RD;
         tswq_pkg::S_EMIT_REL:
            if (status.out_free) state_in = tswq_pkg::S_WALK_RD;
         tswq_pkg::S_EMIT_FIN:
            if (status.out_free) state_in = tswq_pkg::S_IDLE;
         default: state_in = tswq_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         tswq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         tswq_pkg::S_CNT_RD:   cmd.walk_init = status.cnt_zero;
         tswq_pkg::S_CNT_CHK:  cmd.cnt_step = 1'b1;
         tswq_pkg::S_WALK_CHK: begin
            cmd.take = status.hit;
            cmd.keep = !status.hit;
         end
         tswq_pkg::S_EMIT_REL: cmd.emit_rel = status.out_free;
         tswq_pkg::S_EMIT_FIN: cmd.emit_fin = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tswq_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   `TSWQ_ASSERT_NEXT(a_start_leaves_idle, cmd.start, state_ff != tswq_pkg::S_IDLE, "idle after accept")
   `TSWQ_ASSERT_NEXT(a_take_emits, cmd.take, state_ff == tswq_pkg::S_EMIT_REL, "release not emitted")
   `TSWQ_ASSERT_NEXT(a_fin_idle, cmd.emit_fin, state_ff == tswq_pkg::S_IDLE, "no return to idle")

endmodule

>>> src/timed_semaphore_wait_queue.sv
// Timed semaphore wait queue: a FIFO of blocked threads held in a circular memory with one
// registered read port and one write port. One request at a time: an enqueue goes straight to
// its final result; a signal walks the released threads, emitting a result for each, then the
// final one; a tick walks the queue twice (a counting pass over every entry, then a pass that
// keeps or releases each entry); a removal walks once and releases the thread if found. Each
// result waits while the receiver holds off. The walk rate is set by the memory's one
// registered read per entry.
// Depends on tswq_pkg, the channel interfaces, the controller and the datapath.
`timescale 1ns / 1ps

module timed_semaphore_wait_queue #(
   parameter int QUEUE_DEPTH = tswq_pkg::QUEUE_DEPTH
) (
   input logic          clock,
   input logic          reset,
   tswq_req_if.sink     req_ch,
   tswq_rsp_if.source   rsp_ch
);

   tswq_pkg::cmd_type    cmd;
   tswq_pkg::status_type status;

   // sequencing
   tswq_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and result register
   tswq_datapath #(.DEPTH(QUEUE_DEPTH)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_ch.func),
      .req_thread_id      (req_ch.thread_id),
      .req_wait_ticks     (req_ch.wait_ticks),
      .req_wait_forever   (req_ch.wait_forever),
      .req_release_count  (req_ch.release_count),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_woken_id       (rsp_ch.woken_id),
      .rsp_woken          (rsp_ch.woken),
      .rsp_by_signal      (rsp_ch.by_signal),
      .rsp_credit_add     (rsp_ch.credit_add),
      .rsp_released_total (rsp_ch.released_total),
      .rsp_queue_full     (rsp_ch.queue_full),
      .rsp_waiting_count  (rsp_ch.waiting_count),
      .rsp_last_result    (rsp_ch.last_result)
   );

endmodule
